@@ hw/rtl/srtf_pkg.sv @@
// srtf_pkg: shared constants, codes and controller/datapath interface types
// for the shortest-remaining-time-first scheduler. No dependencies.
package srtf_pkg;

   localparam int SLOTS     = 16;
   localparam int TIME_BITS = 16;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int ID_W    = 4;
   localparam int BURST_W = 16;
   localparam int OTIME_W = 16;

   localparam logic ACT_ARRIVE = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'd0,
      ST_REJECT = 2'd1,
      ST_RAN    = 2'd2,
      ST_IDLE   = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic arrive;
      logic scan;
      logic tick;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } dp_stat_type;

endpackage

@@ hw/rtl/srtf_scheduler.sv @@
// srtf_scheduler: top level of the shortest-remaining-time-first scheduler.
// Depends on srtf_pkg; instantiates srtf_ctrl and srtf_datapath.
//
// Usage:
//   req_* beat: req_action selects arrive (place req_proc_id with
//   req_burst_length, stamped with the current time) or tick (run the
//   occupied slot with least remaining time, lowest id on ties, for one unit).
//   rsp_* beat: exactly one per request; status, slot that ran, completion
//   data when it finished, and the time counter after the request.
// Sequence:
//   Arrive: capture, then the arrive state, then the result state, which
//   loads the output register and sets rsp_valid. Tick: a serial scan of
//   all 16 slots over the remaining-time store (one read port, one slot a
//   cycle), then drain, update and result. One request in work.
// Stalls: the result sits in an output register; the next request is
//   taken while it waits, and the following result holds until rsp_ready.
// Reset: synchronous, active high; all slots free, time counter zero.
module srtf_scheduler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [srtf_pkg::ID_W-1:0]      req_proc_id,
   input  logic [srtf_pkg::BURST_W-1:0]   req_burst_length,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [srtf_pkg::ID_W-1:0]      rsp_ran_id,
   output logic                           rsp_finished,
   output logic [srtf_pkg::OTIME_W-1:0]   rsp_finish_time,
   output logic [srtf_pkg::OTIME_W-1:0]   rsp_turnaround,
   output logic [srtf_pkg::OTIME_W-1:0]   rsp_waiting,
   output logic [srtf_pkg::OTIME_W-1:0]   rsp_now
);
   import srtf_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   srtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   srtf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_proc_id      (req_proc_id),
      .req_burst_length (req_burst_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_ran_id       (rsp_ran_id),
      .rsp_finished     (rsp_finished),
      .rsp_finish_time  (rsp_finish_time),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waiting      (rsp_waiting),
      .rsp_now          (rsp_now)
   );

endmodule

@@ hw/rtl/srtf_ctrl.sv @@
// srtf_ctrl: sequencing state machine of the scheduler.
// Depends on srtf_pkg; drives srtf_datapath through dp_cmd_type.
module srtf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  srtf_pkg::dp_stat_type stat,
   output srtf_pkg::dp_cmd_type  cmd
);
   import srtf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ARRIVE,
      S_SCAN,
      S_DRAIN,
      S_TICK,
      S_RESULT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      accept;

   assign accept    = req_valid && req_ready_ff;
   assign req_ready = req_ready_ff;

   always_comb begin
      cmd         = '0;
      cmd.capture = (state_ff == S_IDLE) && accept;
      cmd.arrive  = (state_ff == S_ARRIVE);
      cmd.scan    = (state_ff == S_SCAN);
      cmd.tick    = (state_ff == S_TICK);
      cmd.emit    = (state_ff == S_RESULT) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ready_ff <= 1'b0;
                  state_ff     <= (req_action == ACT_TICK) ? S_SCAN : S_ARRIVE;
               end
            end
            S_ARRIVE: state_ff <= S_RESULT;
            S_SCAN: begin
               if (stat.scan_last) state_ff <= S_DRAIN;
            end
            S_DRAIN:  state_ff <= S_TICK;
            S_TICK:   state_ff <= S_RESULT;
            S_RESULT: begin
               if (stat.out_free) begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/srtf_datapath.sv @@
// srtf_datapath: slot stores, occupancy, time counter, serial minimum scan
// and result register. Depends on srtf_pkg; commanded by srtf_ctrl.
module srtf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  srtf_pkg::dp_cmd_type                cmd,
   output srtf_pkg::dp_stat_type               stat,
   input  logic [srtf_pkg::ID_W-1:0]           req_proc_id,
   input  logic [srtf_pkg::BURST_W-1:0]        req_burst_length,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [srtf_pkg::ID_W-1:0]           rsp_ran_id,
   output logic                                rsp_finished,
   output logic [srtf_pkg::OTIME_W-1:0]        rsp_finish_time,
   output logic [srtf_pkg::OTIME_W-1:0]        rsp_turnaround,
   output logic [srtf_pkg::OTIME_W-1:0]        rsp_waiting,
   output logic [srtf_pkg::OTIME_W-1:0]        rsp_now
);
   import srtf_pkg::*;

   logic [TIME_BITS-1:0] rem_mem [SLOTS];
   logic [TIME_BITS-1:0] arr_mem [SLOTS];
   logic [TIME_BITS-1:0] bst_mem [SLOTS];

   logic [SLOTS-1:0]     occ_ff;
   logic [TIME_BITS-1:0] time_ff;
   logic [ID_W-1:0]      id_ff;
   logic [BURST_W-1:0]   burst_ff;

   logic [SLOT_BITS-1:0] scan_addr_ff;
   logic [SLOT_BITS-1:0] cmp_idx_ff;
   logic                 cmp_vld_ff;
   logic [TIME_BITS-1:0] rem_rd_ff;
   logic                 found_ff;
   logic [SLOT_BITS-1:0] best_ff;
   logic [TIME_BITS-1:0] best_rem_ff;
   logic [TIME_BITS-1:0] arr_rd_ff;
   logic [TIME_BITS-1:0] bst_rd_ff;

   status_type           stat_ff;
   logic                 fin_ff;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [ID_W-1:0]      rsp_ran_id_ff;
   logic                 rsp_finished_ff;
   logic [OTIME_W-1:0]   rsp_finish_time_ff;
   logic [OTIME_W-1:0]   rsp_turnaround_ff;
   logic [OTIME_W-1:0]   rsp_waiting_ff;
   logic [OTIME_W-1:0]   rsp_now_ff;

   logic [SLOT_BITS-1:0] id_idx;
   logic                 id_in_range;
   logic [TIME_BITS-1:0] burst_t;
   logic                 arr_ok;
   logic [TIME_BITS-1:0] rem_dec;
   logic                 rem_zero;
   logic                 cmp_take;
   logic [TIME_BITS-1:0] tat_w;
   logic [TIME_BITS-1:0] wt_w;
   logic                 out_free;

   assign id_idx      = SLOT_BITS'(id_ff);
   assign id_in_range = (32'(id_ff) < 32'(SLOTS));
   assign burst_t     = TIME_BITS'(burst_ff);
   assign arr_ok      = id_in_range && !occ_ff[id_idx] && (burst_t != '0);
   assign rem_dec     = best_rem_ff - TIME_BITS'(1);
   assign rem_zero    = (rem_dec == '0);
   assign cmp_take    = cmp_vld_ff && occ_ff[cmp_idx_ff] &&
                        (!found_ff || (rem_rd_ff < best_rem_ff));
   assign tat_w       = time_ff - arr_rd_ff;
   assign wt_w        = tat_w - bst_rd_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign stat.scan_last = (scan_addr_ff == SLOT_BITS'(SLOTS - 1));
   assign stat.out_free  = out_free;

   // slot stores: one write port each, registered reads
   always_ff @(posedge clock) begin
      if (cmd.arrive && arr_ok) begin
         rem_mem[id_idx] <= burst_t;
         bst_mem[id_idx] <= burst_t;
         arr_mem[id_idx] <= time_ff;
      end else if (cmd.tick && found_ff) begin
         rem_mem[best_ff] <= rem_dec;
      end
      if (cmd.scan) rem_rd_ff <= rem_mem[scan_addr_ff];
      if (cmd.tick) begin
         arr_rd_ff <= arr_mem[best_ff];
         bst_rd_ff <= bst_mem[best_ff];
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         id_ff    <= req_proc_id;
         burst_ff <= req_burst_length;
      end
      if (cmd.scan) cmp_idx_ff <= scan_addr_ff;
      if (cmd.capture) begin
         found_ff <= 1'b0;
      end else if (cmp_take) begin
         found_ff    <= 1'b1;
         best_ff     <= cmp_idx_ff;
         best_rem_ff <= rem_rd_ff;
      end
      if (cmd.arrive) begin
         stat_ff <= arr_ok ? ST_ACCEPT : ST_REJECT;
         fin_ff  <= 1'b0;
      end else if (cmd.tick) begin
         stat_ff <= found_ff ? ST_RAN : ST_IDLE;
         fin_ff  <= found_ff && rem_zero;
      end
      if (cmd.emit) begin
         rsp_status_ff      <= stat_ff;
         rsp_ran_id_ff      <= (stat_ff == ST_RAN) ? ID_W'(best_ff) : '0;
         rsp_finished_ff    <= fin_ff;
         rsp_finish_time_ff <= fin_ff ? OTIME_W'(time_ff) : '0;
         rsp_turnaround_ff  <= fin_ff ? OTIME_W'(tat_w) : '0;
         rsp_waiting_ff     <= fin_ff ? OTIME_W'(wt_w) : '0;
         rsp_now_ff         <= OTIME_W'(time_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         time_ff      <= '0;
         scan_addr_ff <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan;
         if (cmd.capture) scan_addr_ff <= '0;
         else if (cmd.scan) scan_addr_ff <= scan_addr_ff + SLOT_BITS'(1);
         if (cmd.arrive && arr_ok) occ_ff[id_idx] <= 1'b1;
         else if (cmd.tick && found_ff && rem_zero) occ_ff[best_ff] <= 1'b0;
         if (cmd.tick) time_ff <= time_ff + TIME_BITS'(1);
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_ran_id      = rsp_ran_id_ff;
   assign rsp_finished    = rsp_finished_ff;
   assign rsp_finish_time = rsp_finish_time_ff;
   assign rsp_turnaround  = rsp_turnaround_ff;
   assign rsp_waiting     = rsp_waiting_ff;
   assign rsp_now         = rsp_now_ff;

`ifndef ASSERT_OFF
   a_arrive_sets_occ: assert property (@(posedge clock) disable iff (reset)
      (cmd.arrive && arr_ok) |=> occ_ff[$past(id_idx)])
      else $error("accepted arrival did not mark its slot occupied");

   a_pick_is_occupied: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && found_ff) |-> occ_ff[best_ff])
      else $error("scan picked a free slot");

   a_tick_advances_time: assert property (@(posedge clock) disable iff (reset)
      cmd.tick |=> (time_ff == $past(time_ff) + TIME_BITS'(1)))
      else $error("time counter did not advance on tick");

   a_finish_only_on_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_finished_ff) |-> (rsp_status_ff == 2'(ST_RAN)))
      else $error("completion reported on a beat that ran nothing");
`endif

endmodule
